// ===== design/ers_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the elevator scheduler.
`default_nettype none

package ers_pkg;

  localparam int NUM_FLOORS = 6;

  localparam int FLOOR_W    = 3;
  localparam int DIR_W      = 2;
  localparam int OP_W       = 2;
  localparam int COUNT_W    = 3;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_FLOOR   = 2'd1;
  localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_IDLE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_BAD  = 2'b10;
  localparam logic [DIR_W-1:0] DIR_DN   = 2'b11;

  typedef struct packed {
    logic cap;       // capture the input transfer
    logic exec;      // apply the item to the request table
    logic sweep_rd;  // table read address comes from the sweep counter
    logic acc_en;    // sweep read data is valid this cycle
    logic decide;    // commit the next target and direction
    logic load_out;  // load the result register
  } ers_cmd_t;

  typedef struct packed {
    logic need_sel;  // the item calls for a new target search
  } ers_stat_t;

endpackage

`default_nettype wire

// ===== design/ers_ctrl.sv =====
// Sequencing state machine of the elevator scheduler: accept, apply, floor sweep, decide, emit.
`default_nettype none

module ers_ctrl #(
  parameter int FLOORS = ers_pkg::NUM_FLOORS,
  localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire ers_pkg::ers_stat_t stat,
  output ers_pkg::ers_cmd_t     cmd,
  output logic [IDX_W-1:0]      sw_idx
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             acc_en_r;
  logic             out_valid_r, out_valid_nxt;
  logic             last_floor;

  assign last_floor = (cnt_r == IDX_W'(FLOORS - 1));
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign sw_idx     = cnt_r;

  always_comb begin
    cmd.cap      = in_tvalid && in_tready;
    cmd.exec     = (state_r == S_EXEC);
    cmd.sweep_rd = (state_r == S_SWEEP);
    cmd.acc_en   = acc_en_r;
    cmd.decide   = (state_r == S_DECIDE);
    cmd.load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cnt_nxt   = '0;
        state_nxt = stat.need_sel ? S_SWEEP : S_DONE;
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (last_floor) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_DONE;
      S_DONE: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_en_r    <= (state_r == S_SWEEP);
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execution");
`endif

endmodule

`default_nettype wire

// ===== design/ers_dpath.sv =====
// Request table, car state, sweep accumulators and result register of the elevator scheduler.
`default_nettype none

module ers_dpath #(
  parameter int FLOORS = ers_pkg::NUM_FLOORS,
  localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1,
  localparam int CNT_W = $clog2(FLOORS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [ers_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [ers_pkg::IN_USER_W-1:0]  in_tuser,
  input  wire ers_pkg::ers_cmd_t              cmd,
  input  wire logic [IDX_W-1:0]               sw_idx,
  output ers_pkg::ers_stat_t                  stat,
  output logic [ers_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int FW = ers_pkg::FLOOR_W;
  localparam int DW = ers_pkg::DIR_W;

  // captured item
  logic [ers_pkg::OP_W-1:0] op_r;
  logic [FW-1:0]            fl_r;
  logic [DW-1:0]            rdir_r;
  logic                     hold_r;

  // car state
  logic [FLOORS-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FW-1:0]     cur_r, cur_nxt;
  logic [DW-1:0]     dir_r, dir_nxt;
  logic [FW-1:0]     tgt_r, tgt_nxt;
  logic              served_r;

  // wanted-direction table
  logic [DW-1:0]    dir_mem [FLOORS];
  logic [DW-1:0]    rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] in_idx;
  logic [FW-1:0]    in_fl;
  logic             mem_we;
  logic [DW-1:0]    wr_data;

  // sweep accumulators
  logic          any_v, up_any, k2_v, up_near_v, dn_near_v, dn_low_v;
  logic [FW-1:0] hi, k1, k2, up_near, up_high, dn_near, dn_low;

  logic             fl_ok;
  logic [IDX_W-1:0] fl_idx, cur_idx;
  logic             pend_set, pend_clr, cur_ld, tgt_clr, srv;
  logic [31:0]      s_int, cur_int;
  logic [FW-1:0]    s_fl;
  logic             s_pend;

  logic [FW-1:0] k2_eff, up_tgt, dn_tgt;
  logic [FW:0]   k_sum, cur_twice;
  logic [DW-1:0] dir0, dec_dir;
  logic [FW-1:0] dec_tgt;

  assign in_fl   = in_tdata[FW-1:0];
  assign in_idx  = ((in_fl != '0) && (32'(in_fl) <= FLOORS)) ? IDX_W'(in_fl - FW'(1)) : '0;
  assign rd_addr = cmd.sweep_rd ? sw_idx : in_idx;

  assign fl_ok   = (fl_r != '0) && (32'(fl_r) <= FLOORS);
  assign fl_idx  = IDX_W'(fl_r - FW'(1));
  assign cur_idx = IDX_W'(cur_r - FW'(1));

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_tuser;
      fl_r   <= in_tdata[FW-1:0];
      rdir_r <= in_tdata[FW+DW-1:FW];
      hold_r <= in_tdata[FW+DW];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) dir_mem[fl_idx] <= wr_data;
    rd_data_r <= dir_mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  // apply the item
  always_comb begin
    pend_set     = 1'b0;
    pend_clr     = 1'b0;
    mem_we       = 1'b0;
    wr_data      = rdir_r;
    cur_ld       = 1'b0;
    tgt_clr      = 1'b0;
    srv          = 1'b0;
    stat.need_sel = 1'b0;
    if (cmd.exec) begin
      case (op_r)
        ers_pkg::OP_REQUEST: begin
          if (fl_ok && (rdir_r != ers_pkg::DIR_BAD)) begin
            if (pend_r[fl_idx]) begin
              // merge: car call or opposite hall call drops the wanted direction
              if ((rdir_r == ers_pkg::DIR_IDLE) || (DW'(rd_data_r + rdir_r) == '0)) begin
                mem_we  = 1'b1;
                wr_data = ers_pkg::DIR_IDLE;
              end
            end else if (!((cur_r == fl_r) && (dir_r == ers_pkg::DIR_IDLE))) begin
              pend_set      = 1'b1;
              mem_we        = 1'b1;
              stat.need_sel = !hold_r;
            end
          end
        end
        ers_pkg::OP_FLOOR: begin
          cur_ld = fl_ok;
        end
        ers_pkg::OP_ARRIVE: begin
          if ((cnt_r != '0) && (cur_r == tgt_r)) begin
            pend_clr      = 1'b1;
            tgt_clr       = 1'b1;
            srv           = 1'b1;
            stat.need_sel = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // next target from the sweep results
  always_comb begin
    k2_eff    = k2_v ? k2 : hi;
    k_sum     = {1'b0, k1} + {1'b0, k2_eff};
    cur_twice = {cur_r, 1'b0};
    up_tgt    = up_near_v ? up_near : up_high;
    dn_tgt    = dn_near_v ? dn_near : dn_low;
    if (dir_r == ers_pkg::DIR_IDLE) begin
      dir0 = (cur_twice > k_sum) ? ers_pkg::DIR_UP : ers_pkg::DIR_DN;
    end else begin
      dir0 = dir_r;
    end
    dec_dir = ers_pkg::DIR_IDLE;
    dec_tgt = '0;
    if (any_v) begin
      if (dir0 == ers_pkg::DIR_UP) begin
        if (up_any) begin
          dec_dir = ers_pkg::DIR_UP;
          dec_tgt = up_tgt;
        end else if (dn_low_v) begin
          dec_dir = ers_pkg::DIR_DN;
          dec_tgt = dn_tgt;
        end
      end else begin
        if (dn_low_v) begin
          dec_dir = ers_pkg::DIR_DN;
          dec_tgt = dn_tgt;
        end else if (up_any) begin
          dec_dir = ers_pkg::DIR_UP;
          dec_tgt = up_tgt;
        end
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (pend_set) pend_nxt[fl_idx] = 1'b1;
    if (pend_clr) pend_nxt[cur_idx] = 1'b0;
    cnt_nxt = cnt_r;
    if (pend_set) cnt_nxt = cnt_r + CNT_W'(1);
    if (pend_clr) cnt_nxt = cnt_r - CNT_W'(1);
    cur_nxt = cur_ld ? fl_r : cur_r;
    tgt_nxt = tgt_r;
    dir_nxt = dir_r;
    if (tgt_clr) tgt_nxt = '0;
    if (cmd.decide) begin
      tgt_nxt = dec_tgt;
      dir_nxt = dec_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
      cur_r  <= FW'(1);
      dir_r  <= ers_pkg::DIR_IDLE;
      tgt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      cur_r  <= cur_nxt;
      dir_r  <= dir_nxt;
      tgt_r  <= tgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) served_r <= 1'b0;
    else if (srv) served_r <= 1'b1;
  end

  // one floor per cycle, lowest first
  assign s_int   = 32'(rd_idx_r) + 32'd1;
  assign cur_int = 32'(cur_r);
  assign s_fl    = FW'(s_int);
  assign s_pend  = pend_r[rd_idx_r];

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      any_v     <= 1'b0;
      up_any    <= 1'b0;
      k2_v      <= 1'b0;
      up_near_v <= 1'b0;
      dn_near_v <= 1'b0;
      dn_low_v  <= 1'b0;
      k1        <= FW'(1);
    end else if (cmd.acc_en && s_pend) begin
      any_v <= 1'b1;
      hi    <= s_fl;
      if (s_int < cur_int) begin
        if (rd_data_r == ers_pkg::DIR_UP) k1 <= s_fl;
        if (rd_data_r != ers_pkg::DIR_UP) begin
          dn_near_v <= 1'b1;
          dn_near   <= s_fl;
        end
        if (!dn_low_v) begin
          dn_low_v <= 1'b1;
          dn_low   <= s_fl;
        end
      end else if (s_int > cur_int) begin
        if ((rd_data_r == ers_pkg::DIR_DN) && !k2_v) begin
          k2_v <= 1'b1;
          k2   <= s_fl;
        end
        if ((rd_data_r != ers_pkg::DIR_DN) && !up_near_v) begin
          up_near_v <= 1'b1;
          up_near   <= s_fl;
        end
        up_any  <= 1'b1;
        up_high <= s_fl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= {4'b0000, served_r, ers_pkg::COUNT_W'(cnt_r), cur_r, dir_r, tgt_r};
    end
  end

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(pend_r)))
    else $error("pending count out of step with the request table");
  a_target_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (tgt_r != '0) |-> pend_r[IDX_W'(tgt_r - FW'(1))])
    else $error("target floor has no pending request");
  a_idle_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_r == ers_pkg::DIR_IDLE) |-> (tgt_r == '0))
    else $error("idle car holds a target");
  a_car_floor: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r != '0)
    else $error("car floor is zero");
`endif

endmodule

`default_nettype wire

// ===== design/elevator_request_scheduler_core.sv =====
// Top level of the elevator request scheduler: controller and datapath.
`default_nettype none

// Collective SCAN control of one car over FLOORS floors. Each input transfer is a new
// request, a floor-reached update or an arrival check (selected by in_tuser) and yields
// exactly one result transfer with the target, travel direction, car floor, pending
// count and a served flag. Floor updates, requests that need no new target and arrival
// checks that find nothing go from the apply step straight to the result load; requests
// and arrivals that retarget first run a sweep that reads the wanted-direction table one
// floor per cycle through its single read port, then a drain and a decide step. One item
// is in flight at a time; the next input is taken the cycle after the result is loaded,
// while that result waits in the output register. A result that is not taken holds the
// controller before the load.
module elevator_request_scheduler_core #(
  parameter int FLOORS = ers_pkg::NUM_FLOORS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [2:0] req_floor, [4:3] req_dir, [5] door_hold, [7:6] zero
  input  wire logic [ers_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  wire logic [ers_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [2:0] target, [4:3] travel_dir, [7:5] car_floor, [10:8] pending_count,
  // [11] served, [15:12] zero
  output logic [ers_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

  ers_pkg::ers_cmd_t  cmd;
  ers_pkg::ers_stat_t stat;
  logic [IDX_W-1:0]   sw_idx;

  ers_ctrl #(
    .FLOORS(FLOORS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd),
    .sw_idx    (sw_idx)
  );

  ers_dpath #(
    .FLOORS(FLOORS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd      (cmd),
    .sw_idx   (sw_idx),
    .stat     (stat),
    .out_tdata(out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the elevator request scheduler: directed and random traffic.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ers_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 560;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [ers_pkg::FLOOR_W-1:0] target;
    logic [ers_pkg::DIR_W-1:0]   dir;
    logic [ers_pkg::FLOOR_W-1:0] car;
    logic [ers_pkg::COUNT_W-1:0] count;
    logic                        served;
  } car_status_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ers_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [ers_pkg::IN_USER_W-1:0]  in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ers_pkg::OUT_DATA_W-1:0] out_tdata;

  // scheduler image kept in step with every accepted transfer
  bit [ers_pkg::NUM_FLOORS:1]  req_pending;
  logic [ers_pkg::DIR_W-1:0]   req_want [1:ers_pkg::NUM_FLOORS];
  logic [ers_pkg::FLOOR_W-1:0] car_q;
  logic [ers_pkg::DIR_W-1:0]   travel_q;
  logic [ers_pkg::FLOOR_W-1:0] target_q;

  car_status_t status_due[$];
  int          mismatches;
  int          cycle_count;
  bit          calm_in;
  bit          calm_out;
  int          stall_left;

  elevator_request_scheduler_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One pass in one direction; leaves target_q on the floor chosen.
  function automatic bit sweep_for_target(logic [ers_pkg::DIR_W-1:0] dir);
    bit found;
    found = 1'b0;
    if (dir == ers_pkg::DIR_UP) begin
      for (int i = int'(car_q) + 1; i <= ers_pkg::NUM_FLOORS; i++) begin
        if (!req_pending[i]) continue;
        target_q = ers_pkg::FLOOR_W'(i);
        if (req_want[i] != ers_pkg::DIR_DN) return 1'b1;
        found = 1'b1;
      end
    end else begin
      for (int i = int'(car_q) - 1; i >= 1; i--) begin
        if (!req_pending[i]) continue;
        target_q = ers_pkg::FLOOR_W'(i);
        if (req_want[i] != ers_pkg::DIR_UP) return 1'b1;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic void pick_next_target();
    int lo, hi, k1, k2, down_cost, up_cost, car;
    lo = 0;
    hi = 0;
    car = int'(car_q);
    for (int i = 1; i <= ers_pkg::NUM_FLOORS; i++)
      if (req_pending[i]) begin
        if (lo == 0) lo = i;
        hi = i;
      end
    if (lo == 0) begin
      travel_q = ers_pkg::DIR_IDLE;
      target_q = '0;
      return;
    end
    if (travel_q == ers_pkg::DIR_IDLE) begin
      k1 = 1;
      k2 = hi;
      for (int i = car - 1; i >= 1; i--)
        if (req_pending[i] && req_want[i] == ers_pkg::DIR_UP) begin
          k1 = i;
          break;
        end
      for (int i = car + 1; i <= ers_pkg::NUM_FLOORS; i++)
        if (req_pending[i] && req_want[i] == ers_pkg::DIR_DN) begin
          k2 = i;
          break;
        end
      down_cost = car + 2 * hi - 2 * lo - k2;
      up_cost = -car + 2 * hi - 2 * lo + k1;
      travel_q = (down_cost > up_cost) ? ers_pkg::DIR_UP : ers_pkg::DIR_DN;
    end
    for (int pass = 0; pass < 2; pass++) begin
      if (sweep_for_target(travel_q)) return;
      travel_q = (travel_q == ers_pkg::DIR_UP) ? ers_pkg::DIR_DN : ers_pkg::DIR_UP;
    end
    travel_q = ers_pkg::DIR_IDLE;
    target_q = '0;
  endfunction

  function automatic car_status_t advance_scheduler(logic [ers_pkg::OP_W-1:0] op,
                                                    logic [ers_pkg::FLOOR_W-1:0] fl,
                                                    logic [ers_pkg::DIR_W-1:0] rd,
                                                    bit hold);
    car_status_t st;
    int f;
    bit served;
    f = int'(fl);
    served = 1'b0;
    case (op)
      ers_pkg::OP_REQUEST: begin
        if (f >= 1 && f <= ers_pkg::NUM_FLOORS && rd != ers_pkg::DIR_BAD) begin
          if (req_pending[f]) begin
            // merge: a car call or an opposite hall call drops the wanted direction
            if (rd == ers_pkg::DIR_IDLE ||
                (req_want[f] == ers_pkg::DIR_UP && rd == ers_pkg::DIR_DN) ||
                (req_want[f] == ers_pkg::DIR_DN && rd == ers_pkg::DIR_UP))
              req_want[f] = ers_pkg::DIR_IDLE;
          end else if (!(car_q == fl && travel_q == ers_pkg::DIR_IDLE)) begin
            req_pending[f] = 1'b1;
            req_want[f] = rd;
            if (!hold) pick_next_target();
          end
        end
      end
      ers_pkg::OP_FLOOR: begin
        if (f >= 1 && f <= ers_pkg::NUM_FLOORS) car_q = fl;
      end
      ers_pkg::OP_ARRIVE: begin
        if (req_pending != '0 && car_q == target_q) begin
          req_pending[int'(car_q)] = 1'b0;
          req_want[int'(car_q)] = ers_pkg::DIR_IDLE;
          target_q = '0;
          served = 1'b1;
          pick_next_target();
        end
      end
      default: ;
    endcase
    st.target = target_q;
    st.dir = travel_q;
    st.car = car_q;
    st.count = ers_pkg::COUNT_W'($countones(req_pending));
    st.served = served;
    return st;
  endfunction

  task automatic send_item(input logic [ers_pkg::OP_W-1:0] op,
                           input logic [ers_pkg::FLOOR_W-1:0] fl,
                           input logic [ers_pkg::DIR_W-1:0] rd, input bit hold);
    int gap;
    gap = pick_gap(calm_in);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, hold, rd, fl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_due.push_back(advance_scheduler(op, fl, rd, hold));
  endtask

  // Run the car to each target in turn until no request is left.
  task automatic serve_all();
    int spare;
    for (int n = 0; n < 40 && req_pending != '0; n++) begin
      if (target_q == '0) begin
        spare = 0;
        for (int i = 1; i <= ers_pkg::NUM_FLOORS; i++)
          if (spare == 0 && !req_pending[i] && ers_pkg::FLOOR_W'(i) != car_q) spare = i;
        if (spare == 0) break;
        send_item(ers_pkg::OP_REQUEST, ers_pkg::FLOOR_W'(spare), ers_pkg::DIR_IDLE, 1'b0);
      end else if (car_q != target_q) begin
        send_item(ers_pkg::OP_FLOOR, target_q, ers_pkg::DIR_IDLE, 1'b0);
      end else begin
        send_item(ers_pkg::OP_ARRIVE, '0, ers_pkg::DIR_IDLE, 1'b0);
      end
    end
  endtask

  task automatic test_ignored_items();
    send_item(ers_pkg::OP_REQUEST, 3'd0, ers_pkg::DIR_UP, 1'b0);
    send_item(ers_pkg::OP_REQUEST, 3'd7, ers_pkg::DIR_DN, 1'b0);
    send_item(ers_pkg::OP_REQUEST, 3'd3, ers_pkg::DIR_BAD, 1'b0);
    send_item(OP_UNUSED, 3'd5, ers_pkg::DIR_UP, 1'b1);
    send_item(ers_pkg::OP_FLOOR, 3'd0, ers_pkg::DIR_IDLE, 1'b0);
    send_item(ers_pkg::OP_FLOOR, 3'd7, ers_pkg::DIR_IDLE, 1'b0);
    send_item(ers_pkg::OP_ARRIVE, 3'd0, ers_pkg::DIR_IDLE, 1'b0);
    // request for the car's own floor while idle
    send_item(ers_pkg::OP_REQUEST, car_q, ers_pkg::DIR_IDLE, 1'b0);
  endtask

  task automatic test_merge_and_scan();
    send_item(ers_pkg::OP_REQUEST, 3'd6, ers_pkg::DIR_DN, 1'b0);
    send_item(ers_pkg::OP_REQUEST, 3'd3, ers_pkg::DIR_UP, 1'b1);
    send_item(ers_pkg::OP_REQUEST, 3'd5, ers_pkg::DIR_DN, 1'b1);
    send_item(ers_pkg::OP_REQUEST, 3'd2, ers_pkg::DIR_IDLE, 1'b0);
    send_item(ers_pkg::OP_REQUEST, 3'd5, ers_pkg::DIR_UP, 1'b0);
    send_item(ers_pkg::OP_REQUEST, 3'd3, ers_pkg::DIR_IDLE, 1'b0);
    send_item(ers_pkg::OP_REQUEST, 3'd6, ers_pkg::DIR_DN, 1'b0);
    send_item(ers_pkg::OP_ARRIVE, 3'd0, ers_pkg::DIR_IDLE, 1'b0);
    send_item(ers_pkg::OP_REQUEST, 3'd1, ers_pkg::DIR_UP, 1'b0);
    serve_all();
  endtask

  task automatic test_held_request_on_car_floor();
    logic [ers_pkg::FLOOR_W-1:0] f;
    f = (car_q == 3'd6) ? 3'd2 : car_q + 3'd1;
    send_item(ers_pkg::OP_REQUEST, f, ers_pkg::DIR_DN, 1'b1);
    send_item(ers_pkg::OP_FLOOR, f, ers_pkg::DIR_IDLE, 1'b0);
    send_item(ers_pkg::OP_REQUEST, (f > 3'd3) ? 3'd1 : 3'd6, ers_pkg::DIR_IDLE, 1'b0);
    serve_all();
  endtask

  task automatic test_random_traffic();
    int useful, r;
    logic [ers_pkg::DIR_W-1:0] rd;
    logic [ers_pkg::FLOOR_W-1:0] fl;
    bit hold;
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // raw fields, out-of-range codes included
        hold = $urandom_range(0, 1);
        if ($countones(req_pending) >= 4) hold = 1'b0;
        send_item(ers_pkg::OP_W'($urandom_range(0, 3)), ers_pkg::FLOOR_W'($urandom_range(0, 7)),
                  ers_pkg::DIR_W'($urandom_range(0, 3)), hold);
        continue;
      end
      useful++;
      if (target_q != '0 && r < 50) begin
        if (car_q == target_q) begin
          send_item(ers_pkg::OP_ARRIVE, ers_pkg::FLOOR_W'($urandom_range(0, 7)),
                    ers_pkg::DIR_IDLE, 1'b0);
        end else if ($urandom_range(0, 9) < 3) begin
          send_item(ers_pkg::OP_FLOOR, target_q, ers_pkg::DIR_IDLE, 1'b0);
        end else begin
          fl = (car_q < target_q) ? car_q + 3'd1 : car_q - 3'd1;
          send_item(ers_pkg::OP_FLOOR, fl, ers_pkg::DIR_IDLE, 1'b0);
        end
      end else if (r < 58) begin
        send_item(ers_pkg::OP_ARRIVE, '0, ers_pkg::DIR_IDLE, 1'b0);
      end else if (r < 66) begin
        send_item(ers_pkg::OP_FLOOR, ers_pkg::FLOOR_W'($urandom_range(1, ers_pkg::NUM_FLOORS)),
                  ers_pkg::DIR_IDLE, 1'b0);
      end else begin
        case ($urandom_range(0, 2))
          0: rd = ers_pkg::DIR_IDLE;
          1: rd = ers_pkg::DIR_UP;
          default: rd = ers_pkg::DIR_DN;
        endcase
        hold = ($countones(req_pending) < 4) && ($urandom_range(0, 7) == 0);
        send_item(ers_pkg::OP_REQUEST,
                  ers_pkg::FLOOR_W'($urandom_range(1, ers_pkg::NUM_FLOORS)), rd, hold);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    car_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_due.size() == 0) begin
        $display("%0t: result transfer with none expected, expected none, actual %h",
                 $time, out_tdata);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("target", want.target, out_tdata[2:0]);
        check_field("travel_dir", want.dir, out_tdata[4:3]);
        check_field("car_floor", want.car, out_tdata[7:5]);
        check_field("pending_count", want.count, out_tdata[10:8]);
        check_field("served", want.served, out_tdata[11]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("** elevator_request_scheduler_core: FAILED **");
      $finish;
    end
  end

  // switch either side between quiet stretches and random stalls
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm_in = ($urandom_range(0, 2) == 0);
      calm_out = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(calm_out);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    mismatches = 0;
    cycle_count = 0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    req_pending = '0;
    for (int i = 1; i <= ers_pkg::NUM_FLOORS; i++) req_want[i] = ers_pkg::DIR_IDLE;
    car_q = 3'd1;
    travel_q = ers_pkg::DIR_IDLE;
    target_q = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ignored_items();
    test_merge_and_scan();
    test_held_request_on_car_floor();
    test_random_traffic();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("** elevator_request_scheduler_core: PASSED **");
    end else begin
      $display("** elevator_request_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
